/* rtl/dcn_pkg.sv */
`timescale 1ns / 1ps
package dcn_pkg;

  // wide working width: covers every intermediate sum of Q24 products
  localparam int WIDE_W = 44;
  typedef logic signed [WIDE_W-1:0] wide_t;
  typedef logic signed [31:0] word_t;

  localparam logic [WIDE_W-1:0] WIDE_CAP = 44'd1099511627775;
  localparam wide_t ONE_Q24 = 44'sd16777216;
  localparam logic [63:0] LN2_Q32 = 64'd2977044472;

  // register indexes of the configuration port
  localparam int CFG_IDX_W = 3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_X = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_U = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF_I = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_D = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_GAIN_E = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_LOOP_K = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_SAT_CUR = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_INV_NVT = 3'd7;

  // datapath operations
  localparam int OP_W = 5;
  typedef logic [OP_W-1:0] op_t;
  localparam op_t OP_MX   = 5'd0;   // a = cx*x
  localparam op_t OP_MU   = 5'd1;   // acc += cu*u
  localparam op_t OP_MI   = 5'd2;   // acc += ci*i
  localparam op_t OP_MDI  = 5'd3;   // p = d*acc
  localparam op_t OP_MDU  = 5'd4;   // acc = d*cu + e
  localparam op_t OP_MPI  = 5'd5;   // p += acc*in
  localparam op_t OP_MARG = 5'd6;   // arg = v*inv_nvt
  localparam op_t OP_EXP1 = 5'd7;   // e1 = exp(arg/2)
  localparam op_t OP_EXP2 = 5'd8;   // e2 = exp(-arg)
  localparam op_t OP_MCUR = 5'd9;   // cur = Is*(e1-e2)
  localparam op_t OP_MG   = 5'd10;  // g = p + K*cur - v
  localparam op_t OP_MS   = 5'd11;  // acc = Is*(e1/2+e2)
  localparam op_t OP_MK   = 5'd12;  // acc = K*acc
  localparam op_t OP_MJ   = 5'd13;  // jac = acc*inv_nvt - 1
  localparam op_t OP_DIV  = 5'd14;  // v -= g/jac
  localparam op_t OP_MXU  = 5'd15;  // acc = a + cu*(in+u)
  localparam op_t OP_MXI  = 5'd16;  // acc += ci*(cur+i)

  typedef struct packed {
    logic start;
    op_t  op;
    logic load;
    logic store;
  } dcn_cmd_t;

  typedef struct packed {
    logic done;
    logic jac_zero;
    logic conv;
  } dcn_sts_t;

  function automatic word_t sat32(input wide_t v);
    word_t r;
    if (v > 44'sd2147483647) begin
      r = 32'sh7FFFFFFF;
    end else if (v < -44'sd2147483648) begin
      r = 32'sh80000000;
    end else begin
      r = word_t'(v[31:0]);
    end
    return r;
  endfunction

endpackage

/* rtl/dcn_mul.sv */
`timescale 1ns / 1ps
// Q24 sign-magnitude multiplier, 44x22 partial products in separate steps
module dcn_mul (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dcn_pkg::wide_t op_a,
  input  dcn_pkg::wide_t op_b,
  output logic          done,
  output dcn_pkg::wide_t res
);

  localparam int W = dcn_pkg::WIDE_W;
  localparam int H = W / 2;

  logic [W-1:0]     ma_r, mb_r;
  logic             neg_r;
  logic [W+H-1:0]   lo_r;
  logic [2*W-1:0]   prod_r;
  logic [1:0]       step_r;
  logic             done_r;
  dcn_pkg::wide_t   res_r;

  logic [W-1:0]     ma_c, mb_c;
  logic [W+H-1:0]   hi_c;
  logic [2*W-25:0]  sh_c;
  logic [W-1:0]     cap_c;

  always_comb begin
    ma_c = op_a[W-1] ? W'(-op_a) : W'(op_a);
    mb_c = op_b[W-1] ? W'(-op_b) : W'(op_b);
    hi_c = {{H{1'b0}}, ma_r} * {{W{1'b0}}, mb_r[W-1:H]};
    sh_c = prod_r[2*W-1:24];
    cap_c = (sh_c > (2*W-24)'(dcn_pkg::WIDE_CAP)) ? dcn_pkg::WIDE_CAP : sh_c[W-1:0];
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 2'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == 2'd3);
      if (start) begin
        step_r <= 2'd1;
      end else if (step_r != 2'd0) begin
        step_r <= step_r + 2'd1;
      end
    end
  end

  // operands and partial products
  always_ff @(posedge clk) begin
    if (start) begin
      ma_r  <= ma_c;
      mb_r  <= mb_c;
      neg_r <= op_a[W-1] ^ op_b[W-1];
    end
    if (step_r == 2'd1) begin
      lo_r <= {{H{1'b0}}, ma_r} * {{W{1'b0}}, mb_r[H-1:0]};
    end
    if (step_r == 2'd2) begin
      prod_r <= {{(W-H){1'b0}}, lo_r} + {hi_c[W+H-1:0], {(W-H){1'b0}}};
    end
    if (step_r == 2'd3) begin
      res_r <= neg_r ? -dcn_pkg::wide_t'(cap_c) : dcn_pkg::wide_t'(cap_c);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/dcn_div.sv */
`timescale 1ns / 1ps
// Q24 restoring divider, one quotient bit per cycle, result capped
module dcn_div (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dcn_pkg::wide_t num,
  input  dcn_pkg::wide_t den,
  output logic          done,
  output dcn_pkg::wide_t quo
);

  localparam int W  = dcn_pkg::WIDE_W;
  localparam int NW = W + 24;
  localparam int CW = $clog2(NW + 1);

  logic [NW-1:0]  nq_r;
  logic [W-1:0]   rem_r, den_r;
  logic           neg_r, busy_r, done_r;
  logic [CW-1:0]  cnt_r;
  dcn_pkg::wide_t quo_r;

  logic [W-1:0]   mn_c, md_c, cap_c;
  logic [W:0]     r2_c;
  logic           ge_c;

  always_comb begin
    mn_c  = num[W-1] ? W'(-num) : W'(num);
    md_c  = den[W-1] ? W'(-den) : W'(den);
    r2_c  = {rem_r, nq_r[NW-1]};
    ge_c  = r2_c >= {1'b0, den_r};
    cap_c = (nq_r > NW'(dcn_pkg::WIDE_CAP)) ? dcn_pkg::WIDE_CAP : nq_r[W-1:0];
  end

  // control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        if (cnt_r != '0) begin
          cnt_r <= cnt_r - CW'(1);
        end else begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  // shift-subtract datapath
  always_ff @(posedge clk) begin
    if (start) begin
      nq_r  <= {mn_c, 24'd0};
      rem_r <= '0;
      den_r <= md_c;
      neg_r <= num[W-1] ^ den[W-1];
    end else if (busy_r && cnt_r != '0) begin
      rem_r <= ge_c ? W'(r2_c - {1'b0, den_r}) : r2_c[W-1:0];
      nq_r  <= {nq_r[NW-2:0], ge_c};
    end
    if (busy_r && cnt_r == '0) begin
      quo_r <= neg_r ? -dcn_pkg::wide_t'(cap_c) : dcn_pkg::wide_t'(cap_c);
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/dcn_exp.sv */
`timescale 1ns / 1ps
// exp of a Q24 argument via 2^x: table of fractional powers, linear interpolation
module dcn_exp #(
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  dcn_pkg::wide_t arg,
  output logic          done,
  output dcn_pkg::wide_t res
);

  localparam int W  = dcn_pkg::WIDE_W;
  localparam int IW = $clog2(EXP_TABLE_DEPTH + 1);
  localparam int XW = $clog2(EXP_TABLE_DEPTH);
  localparam logic signed [54:0] EXP_BIAS  = 55'sd4503599627370496;
  localparam logic signed [54:0] LOG2E_Q24 = 55'sd24204406;

  // Q2.30 table entry k: 2^(k/depth) by integer series
  function automatic logic [31:0] pow2_entry(input int k);
    logic [63:0] t, sum, term;
    logic        stop;
    int          n;
    t    = (64'(k) * dcn_pkg::LN2_Q32) / 64'(EXP_TABLE_DEPTH);
    sum  = 64'd1 << 32;
    term = 64'd1 << 32;
    stop = 1'b0;
    for (n = 1; n < 40; n++) begin
      if (!stop) begin
        term = ((term * t) >> 32) / 64'(n);
        if (term == 64'd0) begin
          stop = 1'b1;
        end else begin
          sum = sum + term;
        end
      end
    end
    return 32'((sum + 64'd2) >> 2);
  endfunction

  logic [31:0] tab_w [EXP_TABLE_DEPTH+1];

  for (genvar k = 0; k <= EXP_TABLE_DEPTH; k++) begin : g_tab
    localparam logic [31:0] ENTRY = pow2_entry(k);
    assign tab_w[k] = ENTRY;
  end

  logic [2:0]          step_r;
  logic                done_r;
  logic signed [28:0]  ac_r;
  logic [23:0]         f_r, frac_r;
  logic signed [6:0]   n_r;
  logic [XW-1:0]       idx_r;
  logic [31:0]         base_r, nxt_r;
  dcn_pkg::wide_t      res_r;

  logic signed [28:0]  ac_c;
  logic signed [54:0]  y_c;
  logic [24+XW-1:0]    pos_c;
  logic [31:0]         diff_c;
  logic [55:0]         pf_c;
  logic [32:0]         m_c;
  logic signed [6:0]   sh_c, shn_c;
  logic [W-1:0]        ev_c;

  always_comb begin
    // clamp to [-8, +8]
    if (arg > 44'sd134217728) begin
      ac_c = 29'sd134217728;
    end else if (arg < -44'sd134217728) begin
      ac_c = -29'sd134217728;
    end else begin
      ac_c = arg[28:0];
    end
    y_c    = 55'(ac_r) * LOG2E_Q24 + EXP_BIAS;
    pos_c  = (24+XW)'(f_r) * (24+XW)'(EXP_TABLE_DEPTH);
    diff_c = nxt_r - base_r;
    pf_c   = {24'd0, diff_c} * {32'd0, frac_r};
    m_c    = (nxt_r >= base_r) ? ({1'b0, base_r} + {1'b0, pf_c[55:24]}) : {1'b0, base_r};
    sh_c   = n_r - 7'sd6;
    shn_c  = -sh_c;
    if (!sh_c[6]) begin
      ev_c = {{(W-33){1'b0}}, m_c} << sh_c[2:0];
    end else begin
      ev_c = {{(W-33){1'b0}}, m_c} >> shn_c[4:0];
    end
  end

  // step control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      step_r <= 3'd0;
      done_r <= 1'b0;
    end else begin
      done_r <= (step_r == 3'd4);
      if (start) begin
        step_r <= 3'd1;
      end else if (step_r == 3'd4) begin
        step_r <= 3'd0;
      end else if (step_r != 3'd0) begin
        step_r <= step_r + 3'd1;
      end
    end
  end

  // clamp, log2 e scaling, table index, lookup, interpolation and shift
  always_ff @(posedge clk) begin
    if (start) begin
      ac_r <= ac_c;
    end
    if (step_r == 3'd1) begin
      f_r <= y_c[47:24];
      n_r <= $signed({1'b0, y_c[53:48]}) - 7'sd16;
    end
    if (step_r == 3'd2) begin
      idx_r  <= pos_c[24+XW-1:24];
      frac_r <= pos_c[23:0];
    end
    if (step_r == 3'd3) begin
      base_r <= tab_w[IW'(idx_r)];
      nxt_r  <= tab_w[IW'(idx_r) + IW'(1)];
    end
    if (step_r == 3'd4) begin
      res_r <= dcn_pkg::wide_t'(ev_c);
    end
  end

  assign done = done_r;
  assign res  = res_r;

endmodule

/* rtl/dcn_dp.sv */
`timescale 1ns / 1ps
// datapath: registers, state, config, operand selection and shared units
module dcn_dp #(
  parameter int TOLERANCE_LSB   = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  dcn_pkg::dcn_cmd_t               cmd,
  output dcn_pkg::dcn_sts_t               sts,
  input  logic                            cfg_we,
  input  logic [dcn_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [31:0]                     cfg_data,
  input  logic signed [31:0]              sample_in,
  output logic signed [31:0]              voltage_out
);

  localparam int W = dcn_pkg::WIDE_W;

  // configuration
  dcn_pkg::word_t cx_r, cu_r, ci_r, gd_r, ge_r, kl_r;
  logic [30:0]    is_r, nvt_r;

  // item state
  dcn_pkg::word_t x_r, u_r, i_r, v_r, in_r, out_r;
  logic           conv_r;

  // working registers
  dcn_pkg::wide_t a_r, acc_r, p_r, arg_r, e1_r, e2_r, cur_r, g_r, jac_r;

  dcn_pkg::wide_t mul_a, mul_b, mul_res, exp_arg, exp_res, div_q;
  dcn_pkg::wide_t arg_adj, vdiff, is_w, nvt_w;
  logic           mul_sel, mul_done, exp_done, div_done;
  dcn_pkg::word_t vn_c;
  logic signed [32:0] dv_c;
  logic [32:0]    eps_c;

  always_comb begin
    is_w  = dcn_pkg::wide_t'({{(W-31){1'b0}}, is_r});
    nvt_w = dcn_pkg::wide_t'({{(W-31){1'b0}}, nvt_r});
    // operand selection for the shared multiplier
    mul_sel = 1'b1;
    mul_a   = '0;
    mul_b   = '0;
    case (cmd.op)
      dcn_pkg::OP_MX:   begin mul_a = dcn_pkg::wide_t'(cx_r); mul_b = dcn_pkg::wide_t'(x_r); end
      dcn_pkg::OP_MU:   begin mul_a = dcn_pkg::wide_t'(cu_r); mul_b = dcn_pkg::wide_t'(u_r); end
      dcn_pkg::OP_MI:   begin mul_a = dcn_pkg::wide_t'(ci_r); mul_b = dcn_pkg::wide_t'(i_r); end
      dcn_pkg::OP_MDI:  begin mul_a = dcn_pkg::wide_t'(gd_r); mul_b = acc_r; end
      dcn_pkg::OP_MDU:  begin mul_a = dcn_pkg::wide_t'(gd_r); mul_b = dcn_pkg::wide_t'(cu_r); end
      dcn_pkg::OP_MPI:  begin mul_a = acc_r; mul_b = dcn_pkg::wide_t'(in_r); end
      dcn_pkg::OP_MARG: begin mul_a = dcn_pkg::wide_t'(v_r); mul_b = nvt_w; end
      dcn_pkg::OP_MCUR: begin mul_a = is_w; mul_b = e1_r - e2_r; end
      dcn_pkg::OP_MG:   begin mul_a = dcn_pkg::wide_t'(kl_r); mul_b = cur_r; end
      dcn_pkg::OP_MS:   begin mul_a = is_w; mul_b = (e1_r >>> 1) + e2_r; end
      dcn_pkg::OP_MK:   begin mul_a = dcn_pkg::wide_t'(kl_r); mul_b = acc_r; end
      dcn_pkg::OP_MJ:   begin mul_a = acc_r; mul_b = nvt_w; end
      dcn_pkg::OP_MXU:  begin
        mul_a = dcn_pkg::wide_t'(cu_r);
        mul_b = dcn_pkg::wide_t'(in_r) + dcn_pkg::wide_t'(u_r);
      end
      dcn_pkg::OP_MXI:  begin
        mul_a = dcn_pkg::wide_t'(ci_r);
        mul_b = cur_r + dcn_pkg::wide_t'(i_r);
      end
      default: mul_sel = 1'b0;
    endcase
    // exponent argument: arg/2 toward zero, or -arg
    arg_adj = arg_r + dcn_pkg::wide_t'({{(W-1){1'b0}}, arg_r[W-1]});
    exp_arg = (cmd.op == dcn_pkg::OP_EXP1) ? (arg_adj >>> 1) : -arg_r;
    // Newton update
    vdiff = dcn_pkg::wide_t'(v_r) - div_q;
    vn_c  = dcn_pkg::sat32(vdiff);
    dv_c  = 33'(vn_c) - 33'(v_r);
    eps_c = dv_c[32] ? 33'(-dv_c) : 33'(dv_c);
  end

  dcn_mul u_mul (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start & mul_sel),
    .op_a  (mul_a),
    .op_b  (mul_b),
    .done  (mul_done),
    .res   (mul_res)
  );

  dcn_exp #(
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_exp (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start & ((cmd.op == dcn_pkg::OP_EXP1) | (cmd.op == dcn_pkg::OP_EXP2))),
    .arg   (exp_arg),
    .done  (exp_done),
    .res   (exp_res)
  );

  dcn_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.start & (cmd.op == dcn_pkg::OP_DIV)),
    .num   (g_r),
    .den   (jac_r),
    .done  (div_done),
    .quo   (div_q)
  );

  // config registers and item state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cx_r   <= '0;
      cu_r   <= '0;
      ci_r   <= '0;
      gd_r   <= 32'sd16777216;
      ge_r   <= '0;
      kl_r   <= '0;
      is_r   <= 31'd1;
      nvt_r  <= 31'd16777216;
      x_r    <= '0;
      u_r    <= '0;
      i_r    <= '0;
      v_r    <= '0;
      conv_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          dcn_pkg::REG_COEF_X:  cx_r  <= cfg_data;
          dcn_pkg::REG_COEF_U:  cu_r  <= cfg_data;
          dcn_pkg::REG_COEF_I:  ci_r  <= cfg_data;
          dcn_pkg::REG_GAIN_D:  gd_r  <= cfg_data;
          dcn_pkg::REG_GAIN_E:  ge_r  <= cfg_data;
          dcn_pkg::REG_LOOP_K:  kl_r  <= cfg_data;
          dcn_pkg::REG_SAT_CUR: is_r  <= cfg_data[30:0];
          dcn_pkg::REG_INV_NVT: nvt_r <= cfg_data[30:0];
          default: ;
        endcase
      end
      if (div_done) begin
        v_r    <= vn_c;
        conv_r <= eps_c <= 33'(TOLERANCE_LSB);
      end
      if (cmd.store) begin
        x_r <= dcn_pkg::sat32(acc_r);
        u_r <= in_r;
        i_r <= dcn_pkg::sat32(cur_r);
      end
    end
  end

  // working registers: sample on load, output on store, unit results on completion
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      in_r <= sample_in;
    end
    if (cmd.store) begin
      out_r <= v_r;
    end
    if (exp_done) begin
      if (cmd.op == dcn_pkg::OP_EXP1) begin
        e1_r <= exp_res;
      end else begin
        e2_r <= exp_res;
      end
    end
    if (mul_done) begin
      case (cmd.op)
        dcn_pkg::OP_MX:   begin a_r <= mul_res; acc_r <= mul_res; end
        dcn_pkg::OP_MU:   acc_r <= acc_r + mul_res;
        dcn_pkg::OP_MI:   acc_r <= acc_r + mul_res;
        dcn_pkg::OP_MDI:  p_r <= mul_res;
        dcn_pkg::OP_MDU:  acc_r <= mul_res + dcn_pkg::wide_t'(ge_r);
        dcn_pkg::OP_MPI:  p_r <= p_r + mul_res;
        dcn_pkg::OP_MARG: arg_r <= mul_res;
        dcn_pkg::OP_MCUR: cur_r <= mul_res;
        dcn_pkg::OP_MG:   g_r <= p_r + mul_res - dcn_pkg::wide_t'(v_r);
        dcn_pkg::OP_MS:   acc_r <= mul_res;
        dcn_pkg::OP_MK:   acc_r <= mul_res;
        dcn_pkg::OP_MJ:   jac_r <= mul_res - dcn_pkg::ONE_Q24;
        dcn_pkg::OP_MXU:  acc_r <= a_r + mul_res;
        dcn_pkg::OP_MXI:  acc_r <= acc_r + mul_res;
        default: ;
      endcase
    end
  end

  assign sts.done     = mul_done | exp_done | div_done;
  assign sts.jac_zero = (jac_r == '0);
  assign sts.conv     = conv_r;
  assign voltage_out  = out_r;

endmodule

/* rtl/dcn_ctrl.sv */
`timescale 1ns / 1ps
// controller: sequences datapath operations, Newton loop and handshakes
module dcn_ctrl #(
  parameter int MAX_ITERATIONS = 8
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  input  dcn_pkg::dcn_sts_t sts,
  output dcn_pkg::dcn_cmd_t cmd
);

  localparam int IT_W = $clog2(MAX_ITERATIONS + 1);

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_ISSUE  = 3'd1;
  localparam logic [2:0] ST_WAIT   = 3'd2;
  localparam logic [2:0] ST_DECIDE = 3'd3;
  localparam logic [2:0] ST_STORE  = 3'd4;

  logic [2:0]       state_r, state_nxt;
  dcn_pkg::op_t     op_r, op_nxt;
  logic             post_r, post_nxt;
  logic [IT_W-1:0]  iter_r, iter_nxt, iter_inc;
  logic             out_valid_r, out_valid_nxt;
  logic             slot_free, load, store;

  always_comb begin
    state_nxt = state_r;
    op_nxt    = op_r;
    post_nxt  = post_r;
    iter_nxt  = iter_r;
    iter_inc  = iter_r + IT_W'(1);
    slot_free = !out_valid_r || !out_stall;
    load      = 1'b0;
    store     = 1'b0;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          load      = 1'b1;
          op_nxt    = dcn_pkg::OP_MX;
          post_nxt  = 1'b0;
          iter_nxt  = '0;
          state_nxt = ST_ISSUE;
        end
      end
      ST_ISSUE: state_nxt = ST_WAIT;
      ST_WAIT: begin
        if (sts.done) begin
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        state_nxt = ST_ISSUE;
        case (op_r)
          dcn_pkg::OP_MX:   op_nxt = dcn_pkg::OP_MU;
          dcn_pkg::OP_MU:   op_nxt = dcn_pkg::OP_MI;
          dcn_pkg::OP_MI:   op_nxt = dcn_pkg::OP_MDI;
          dcn_pkg::OP_MDI:  op_nxt = dcn_pkg::OP_MDU;
          dcn_pkg::OP_MDU:  op_nxt = dcn_pkg::OP_MPI;
          dcn_pkg::OP_MPI:  op_nxt = dcn_pkg::OP_MARG;
          dcn_pkg::OP_MARG: op_nxt = dcn_pkg::OP_EXP1;
          dcn_pkg::OP_EXP1: op_nxt = dcn_pkg::OP_EXP2;
          dcn_pkg::OP_EXP2: op_nxt = dcn_pkg::OP_MCUR;
          dcn_pkg::OP_MCUR: op_nxt = post_r ? dcn_pkg::OP_MXU : dcn_pkg::OP_MG;
          dcn_pkg::OP_MG:   op_nxt = dcn_pkg::OP_MS;
          dcn_pkg::OP_MS:   op_nxt = dcn_pkg::OP_MK;
          dcn_pkg::OP_MK:   op_nxt = dcn_pkg::OP_MJ;
          dcn_pkg::OP_MJ: begin
            // singular Jacobian: leave v as it is
            if (sts.jac_zero) begin
              post_nxt = 1'b1;
              op_nxt   = dcn_pkg::OP_MARG;
            end else begin
              op_nxt = dcn_pkg::OP_DIV;
            end
          end
          dcn_pkg::OP_DIV: begin
            iter_nxt = iter_inc;
            op_nxt   = dcn_pkg::OP_MARG;
            if (sts.conv || iter_inc >= IT_W'(MAX_ITERATIONS)) begin
              post_nxt = 1'b1;
            end
          end
          dcn_pkg::OP_MXU:  op_nxt = dcn_pkg::OP_MXI;
          dcn_pkg::OP_MXI:  state_nxt = ST_STORE;
          default:          state_nxt = ST_IDLE;
        endcase
      end
      ST_STORE: begin
        if (slot_free) begin
          store     = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
    // output register: set on store, cleared when taken
    if (store) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      op_r        <= dcn_pkg::OP_MX;
      post_r      <= 1'b0;
      iter_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      op_r        <= op_nxt;
      post_r      <= post_nxt;
      iter_r      <= iter_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = out_valid_r;
  assign cmd.start = (state_r == ST_ISSUE);
  assign cmd.op    = op_r;
  assign cmd.load  = load;
  assign cmd.store = store;

endmodule

/* rtl/diode_clipper_newton_solver.sv */
`timescale 1ns / 1ps
// Channel   Direction  Handshake            Payload
// input     in         in_valid / in_stall  sample_in     (32, signed Q8.24)
// result    out        out_valid/ out_stall voltage_out   (32, signed Q8.24)
// config    in         cfg_valid/ cfg_ready cfg_index (3), cfg_data (32)
//
// One sample at a time, taking N Newton passes (1 to MAX_ITERATIONS). Each pass
// is dominated by the divider, one quotient bit per cycle over 68 bits, plus six
// multiplies and two exps.
// Synchronous active-low reset restores register defaults and zeroes x, u, i and v.
// A new sample is taken while the previous result waits in the output register;
// a stalled result holds the final store until it is taken.
module diode_clipper_newton_solver #(
  parameter int MAX_ITERATIONS  = 8,
  parameter int TOLERANCE_LSB   = 16,
  parameter int EXP_TABLE_DEPTH = 256
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [31:0]            sample_in,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [31:0]            voltage_out,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [dcn_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]                   cfg_data
);

  dcn_pkg::dcn_cmd_t cmd;
  dcn_pkg::dcn_sts_t sts;

  assign cfg_ready = 1'b1;

  dcn_ctrl #(
    .MAX_ITERATIONS (MAX_ITERATIONS)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .sts       (sts),
    .cmd       (cmd)
  );

  dcn_dp #(
    .TOLERANCE_LSB   (TOLERANCE_LSB),
    .EXP_TABLE_DEPTH (EXP_TABLE_DEPTH)
  ) u_dp (
    .clk         (clk),
    .rst_n       (rst_n),
    .cmd         (cmd),
    .sts         (sts),
    .cfg_we      (cfg_valid & cfg_ready),
    .cfg_index   (cfg_index),
    .cfg_data    (cfg_data),
    .sample_in   (sample_in),
    .voltage_out (voltage_out)
  );

endmodule
